FILE: sv/consistent_hash_ring_lookup_defines.svh
// assertion macros for the consistent hash ring lookup block
`ifndef CONSISTENT_HASH_RING_LOOKUP_DEFINES_SVH
`define CONSISTENT_HASH_RING_LOOKUP_DEFINES_SVH

`ifndef SYNTH
`define CHRL_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("check failed: implication");
`define CHRL_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("check failed: next cycle");
`else
`define CHRL_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define CHRL_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

FILE: sv/chrl_pkg.sv
// types, codes and helpers shared by the ring lookup modules
package chrl_pkg;

  // request codes on req_type
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_KEY    = 2'd2;
  localparam logic [1:0] REQ_RANDOM = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_DROP  = 2'd2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPW = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_INSERT,
    OP_LOOKUP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [3:0][31:0] pts;
    logic [7:0]       node;
  } cmd_t;

  typedef struct packed {
    logic [31:0] point;
    logic [7:0]  node;
  } entry_t;

  typedef struct packed {
    logic [7:0]  node;
    logic [31:0] point;
    logic [1:0]  status;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_START,
    ST_INS_CMP,
    ST_LK_PROBE,
    ST_LK_CMP,
    ST_LK_FETCH,
    ST_DONE
  } state_t;

  // true when entry a sorts strictly after entry b
  function automatic logic entry_after(entry_t a, entry_t b);
    if (a.point != b.point) begin
      return a.point > b.point;
    end
    return a.node > b.node;
  endfunction

endpackage

FILE: sv/chrl_front.sv
// front end: classifies items and builds ring commands
module chrl_front #(
  parameter int NODE_COUNT = 256
) (
  input  logic           push,
  input  logic           full,
  input  logic [1:0]     req_type,
  input  logic [31:0]    word0,
  input  logic [31:0]    word1,
  input  logic [31:0]    word2,
  input  logic [31:0]    word3,
  input  logic [7:0]     node_in,
  output logic           enq,
  output chrl_pkg::cmd_t cmd
);

  logic [7:0] node_clamped;

  // ids past the node range fold onto the last node
  always_comb begin
    if (32'(node_in) >= 32'(NODE_COUNT)) begin
      node_clamped = 8'(NODE_COUNT - 1);
    end else begin
      node_clamped = node_in;
    end
  end

  always_comb begin
    cmd.pts  = {word3, word2, word1, word0};
    cmd.node = node_clamped;
    case (req_type)
      chrl_pkg::REQ_CLEAR: begin
        cmd.op = chrl_pkg::OP_CLEAR;
      end
      chrl_pkg::REQ_INSERT: begin
        cmd.op = chrl_pkg::OP_INSERT;
      end
      chrl_pkg::REQ_KEY: begin
        cmd.op     = chrl_pkg::OP_LOOKUP;
        cmd.pts[0] = word0 ^ word1 ^ word2 ^ word3;
      end
      default: begin
        cmd.op = chrl_pkg::OP_LOOKUP;
      end
    endcase
  end

  assign enq = push && !full;

endmodule

FILE: sv/chrl_cmd_queue.sv
// short command queue between the front end and the ring engine
module chrl_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           enq,
  input  chrl_pkg::cmd_t cmd_in,
  input  logic           deq,
  output logic           full,
  output logic           empty,
  output chrl_pkg::cmd_t cmd_out
);

  chrl_pkg::cmd_t             slots [chrl_pkg::QUEUE_DEPTH];
  logic [chrl_pkg::QPW-1:0]   wptr;
  logic [chrl_pkg::QPW-1:0]   rptr;
  logic [chrl_pkg::QPW:0]     fill;

  assign full    = fill == (chrl_pkg::QPW + 1)'(chrl_pkg::QUEUE_DEPTH);
  assign empty   = fill == '0;
  assign cmd_out = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (enq) begin
        wptr <= wptr + 1'b1;
      end
      if (deq) begin
        rptr <= rptr + 1'b1;
      end
      if (enq && !deq) begin
        fill <= fill + 1'b1;
      end else if (deq && !enq) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wptr] <= cmd_in;
    end
  end

endmodule

FILE: sv/chrl_engine.sv
// ring engine: sorted insert by shifting, binary search lookup, result register
module chrl_engine #(
  parameter int RING_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  chrl_pkg::cmd_t    q_cmd,
  output logic              deq,
  input  logic              pop,
  output logic              out_valid,
  output chrl_pkg::result_t out_res
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam logic [CW-1:0] FULL_AT = CW'(RING_DEPTH - 4);

  chrl_pkg::entry_t  mem [RING_DEPTH];
  chrl_pkg::entry_t  rdata;

  chrl_pkg::state_t  state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     pos, pos_next;
  logic [1:0]        widx, widx_next;
  logic [CW-1:0]     lo, lo_next;
  logic [CW-1:0]     hi, hi_next;
  logic [CW-1:0]     mid, mid_next;
  chrl_pkg::cmd_t    cur, cur_next;
  chrl_pkg::result_t res, res_next;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  chrl_pkg::entry_t  wr_data;
  logic              load_out;
  logic              placed;
  chrl_pkg::entry_t  cur_entry;
  logic [CW:0]       mid_sum;
  logic [CW-1:0]     pos_m1;
  logic [CW-1:0]     pos_m2;

  assign cur_entry = '{point: cur.pts[widx], node: cur.node};
  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign pos_m1    = pos - CW'(1);
  assign pos_m2    = pos - CW'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chrl_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    pos  <= pos_next;
    widx <= widx_next;
    lo   <= lo_next;
    hi   <= hi_next;
    mid  <= mid_next;
    cur  <= cur_next;
    res  <= res_next;
  end

  always_comb begin
    state_next = state;
    count_next = count;
    pos_next   = pos;
    widx_next  = widx;
    lo_next    = lo;
    hi_next    = hi;
    mid_next   = mid;
    cur_next   = cur;
    res_next   = res;
    deq        = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = cur_entry;
    load_out   = 1'b0;
    placed     = 1'b0;
    case (state)
      chrl_pkg::ST_IDLE: begin
        if (!q_empty) begin
          deq      = 1'b1;
          cur_next = q_cmd;
          res_next = '{node: '0, point: '0, status: chrl_pkg::STATUS_OK};
          case (q_cmd.op)
            chrl_pkg::OP_CLEAR: begin
              count_next = '0;
              state_next = chrl_pkg::ST_DONE;
            end
            chrl_pkg::OP_INSERT: begin
              if (count > FULL_AT) begin
                res_next.status = chrl_pkg::STATUS_DROP;
                state_next      = chrl_pkg::ST_DONE;
              end else begin
                widx_next  = '0;
                pos_next   = count;
                state_next = chrl_pkg::ST_INS_START;
              end
            end
            chrl_pkg::OP_LOOKUP: begin
              if (count == '0) begin
                res_next.status = chrl_pkg::STATUS_EMPTY;
                state_next      = chrl_pkg::ST_DONE;
              end else begin
                lo_next    = '0;
                hi_next    = count;
                state_next = chrl_pkg::ST_LK_PROBE;
              end
            end
            default: begin
              state_next = chrl_pkg::ST_DONE;
            end
          endcase
        end
      end
      chrl_pkg::ST_INS_START: begin
        if (pos == '0) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          placed  = 1'b1;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = pos_m1[AW-1:0];
          state_next = chrl_pkg::ST_INS_CMP;
        end
      end
      chrl_pkg::ST_INS_CMP: begin
        // shift one entry up per cycle while the next read is in flight
        if (chrl_pkg::entry_after(rdata, cur_entry)) begin
          wr_en    = 1'b1;
          wr_addr  = pos[AW-1:0];
          wr_data  = rdata;
          pos_next = pos_m1;
          if (pos == CW'(1)) begin
            state_next = chrl_pkg::ST_INS_START;
          end else begin
            rd_en   = 1'b1;
            rd_addr = pos_m2[AW-1:0];
          end
        end else begin
          wr_en   = 1'b1;
          wr_addr = pos[AW-1:0];
          placed  = 1'b1;
        end
      end
      chrl_pkg::ST_LK_PROBE: begin
        if (lo < hi) begin
          mid_next   = mid_sum[CW:1];
          rd_en      = 1'b1;
          rd_addr    = mid_sum[AW:1];
          state_next = chrl_pkg::ST_LK_CMP;
        end else begin
          // nothing above the query wraps to the first entry
          rd_en      = 1'b1;
          rd_addr    = (lo == count) ? '0 : lo[AW-1:0];
          state_next = chrl_pkg::ST_LK_FETCH;
        end
      end
      chrl_pkg::ST_LK_CMP: begin
        if (rdata.point > cur.pts[0]) begin
          hi_next = mid;
        end else begin
          lo_next = mid + CW'(1);
        end
        state_next = chrl_pkg::ST_LK_PROBE;
      end
      chrl_pkg::ST_LK_FETCH: begin
        res_next.node  = rdata.node;
        res_next.point = rdata.point;
        state_next     = chrl_pkg::ST_DONE;
      end
      chrl_pkg::ST_DONE: begin
        if (!out_valid || pop) begin
          load_out   = 1'b1;
          state_next = chrl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = chrl_pkg::ST_IDLE;
      end
    endcase
    if (placed) begin
      count_next = count + CW'(1);
      if (widx == 2'd3) begin
        state_next = chrl_pkg::ST_DONE;
      end else begin
        widx_next  = widx + 2'd1;
        pos_next   = count + CW'(1);
        state_next = chrl_pkg::ST_INS_START;
      end
    end
  end

  // ring storage, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res <= res;
    end
  end

endmodule

FILE: sv/consistent_hash_ring_lookup.sv
// consistent hash ring lookup: top level with queue ports on both sides
// clear, a dropped insert or an empty lookup goes from IDLE straight to DONE, which loads the result
// register; insert: the four points are placed in turn, each by shifting larger entries up one slot
// lookup: binary search over the sorted ring, each probe a read in LK_PROBE and a compare in LK_CMP
// one item in the engine at a time; the next starts the cycle after a result loads
// rst clears the ring count, the command queue and the result valid flag
module consistent_hash_ring_lookup #(
  parameter int RING_DEPTH = 1024,
  parameter int NODE_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst,
  // item input side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type,
  input  logic [31:0] word0,
  input  logic [31:0] word1,
  input  logic [31:0] word2,
  input  logic [31:0] word3,
  input  logic [7:0]  node_in,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  node_out,
  output logic [31:0] point_hit,
  output logic [1:0]  status
);

`include "consistent_hash_ring_lookup_defines.svh"

  // front end to queue
  chrl_pkg::cmd_t    front_cmd;
  logic              enq;
  // queue to engine
  chrl_pkg::cmd_t    q_cmd;
  logic              q_empty;
  logic              deq;
  // result register
  logic              out_valid;
  chrl_pkg::result_t out_res;
  // result node and point as one word for the checks below
  logic [39:0]       res_word;
  logic              res_flagged;

  // classify the item, fold the key, clamp the node id
  chrl_front #(
    .NODE_COUNT(NODE_COUNT)
  ) u_front (
    .push    (push),
    .full    (full),
    .req_type(req_type),
    .word0   (word0),
    .word1   (word1),
    .word2   (word2),
    .word3   (word3),
    .node_in (node_in),
    .enq     (enq),
    .cmd     (front_cmd)
  );

  // lets new items in while the engine is shifting or searching
  chrl_cmd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .enq    (enq),
    .cmd_in (front_cmd),
    .deq    (deq),
    .full   (full),
    .empty  (q_empty),
    .cmd_out(q_cmd)
  );

  // sorted ring memory and the lookup search
  chrl_engine #(
    .RING_DEPTH(RING_DEPTH)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_cmd    (q_cmd),
    .deq      (deq),
    .pop      (pop),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  assign empty     = !out_valid;
  assign node_out  = out_res.node;
  assign point_hit = out_res.point;
  assign status    = out_res.status;

  assign res_word    = {node_out, point_hit};
  assign res_flagged = !empty && (status != chrl_pkg::STATUS_OK);

  // engine only takes commands the queue holds
  `CHRL_ASSERT_IMPLIES(a_deq_has_item, clk, rst, deq, !q_empty)
  // a shown result carries a defined status
  `CHRL_ASSERT_IMPLIES(a_status_known, clk, rst, !empty, status <= chrl_pkg::STATUS_DROP)
  // flagged results carry no point or node
  `CHRL_ASSERT_IMPLIES(a_flag_zero, clk, rst, res_flagged, res_word == '0)
  // a result not taken stays on the ports
  `CHRL_ASSERT_NEXT(a_result_held, clk, rst, (!empty && !pop), (!empty && $stable(res_word)))

endmodule
